// File: hw/rtl/sensor_location_sorter_assert.svh
// assertion macros for the sensor location sorter
// used by the rtl files that carry concurrent checks, no other dependency
`ifndef SENSOR_LOCATION_SORTER_ASSERT_SVH
`define SENSOR_LOCATION_SORTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SLS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SLS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/sls_pkg.sv
// shared types and constants of the sensor location sorter
// no dependencies
package sls_pkg;

   localparam int SLOT_CAPACITY_DEF = 32;
   localparam logic [7:0] NONE_MIN = 8'hff;
   localparam logic [6:0] PAGE_SIZE_RST = 7'd10;

   // control sequencer states
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DIV,
      ST_SCAN,
      ST_EMIT
   } sls_state_type;

   // page divider status
   typedef struct packed {
      logic       done;
      logic [6:0] pages;
   } sls_div_stat_type;

   // one result word before packing
   typedef struct packed {
      logic [5:0] slot_index;
      logic [7:0] out_building;
      logic [7:0] out_unit;
      logic       new_building;
      logic       valid_res;
      logic       last_result;
      logic [6:0] sensor_count;
      logic [6:0] page_count;
      logic [7:0] min_building;
      logic [7:0] max_building;
      logic [7:0] min_unit;
      logic [7:0] max_unit;
   } sls_rsp_type;

endpackage

// File: hw/rtl/sls_mem.sv
// slot store: one write port, one registered read port
// no package dependency
module sls_mem #(
   parameter int DEPTH = 32,
   parameter int IDX_W = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [15:0]      wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [15:0]      rd_data
);

   logic [15:0] mem_ff [DEPTH];
   logic [15:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/sls_pgdiv.sv
// page count unit: ceiling of count over page size by repeated subtraction
// depends on sls_pkg
module sls_pgdiv (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [6:0]                count,
   input  logic [6:0]                page_size,
   output sls_pkg::sls_div_stat_type stat
);

   logic       busy_ff, busy_in;
   logic [6:0] rem_ff, rem_in;
   logic [6:0] pg_ff, pg_in;
   logic [6:0] div;

   // page size zero acts as one
   assign div = (page_size == 7'd0) ? 7'd1 : page_size;

   // one subtraction per cycle while busy
   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      pg_in   = pg_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = count;
         pg_in   = 7'd0;
      end else if (busy_ff) begin
         if (rem_ff == 7'd0) begin
            busy_in = 1'b0;
         end else begin
            rem_in = (rem_ff > div) ? (rem_ff - div) : 7'd0;
            pg_in  = pg_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      pg_ff  <= pg_in;
   end

   assign stat.done  = busy_ff && (rem_ff == 7'd0);
   assign stat.pages = pg_ff;

endmodule

// File: hw/rtl/sensor_location_sorter.sv
// top level of the sensor location sorter: load, page count, selection sort
// depends on sls_pkg, sls_mem, sls_pgdiv and sensor_location_sorter_assert.svh
//
// Slots are taken one word per cycle and, up to the slot capacity, written into the
// slot store. The word marked tlast ends the table; the block then stops taking
// words, runs the page count (ceiling of the occupied slot count over the page
// size), and emits the sorted entries by selection: each entry costs one pass over
// the loaded slots through the single read port of the store plus an emit step,
// and may be held by an output stall. A closing pass that finds nothing more ends
// the run. After the final result is handed to the output register, loading of
// the next table starts at once. Every result word also carries the run summary.
`include "sensor_location_sorter_assert.svh"

module sensor_location_sorter #(
   parameter int SLOT_CAPACITY = sls_pkg::SLOT_CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // slot input; tdata: building[7:0], unit[15:8]; tlast: last_slot
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tlast,
   // results; tdata: slot_index[5:0], out_building[13:6], out_unit[21:14],
   // sensor_count[28:22], page_count[35:29], min_building[43:36],
   // max_building[51:44], min_unit[59:52], max_unit[67:60], zero [71:68]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,
   // tuser: new_building[0], valid_res[1]; tlast: last_result
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   // page size register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);

   localparam int IDX_W = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
   localparam int LC_W  = $clog2(SLOT_CAPACITY + 1);
   localparam logic [LC_W-1:0] CAP = LC_W'(SLOT_CAPACITY);

   sls_pkg::sls_state_type    state_ff, state_in;
   sls_pkg::sls_div_stat_type div_stat;
   sls_pkg::sls_rsp_type      rsp_ff, rsp_in;

   logic [6:0]      page_ff;
   logic [LC_W-1:0] load_cnt_ff, load_cnt_in;
   logic [6:0]      occ_ff, occ_in;
   logic [7:0]      bmin_ff, bmin_in, bmax_ff, bmax_in;
   logic [7:0]      umin_ff, umin_in, umax_ff, umax_in;
   logic            div_start_ff;
   logic [6:0]      pages_ff, pages_in;

   logic [LC_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             found_ff, found_in;
   logic [15:0]      best_key_ff, best_key_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic             have_prev_ff, have_prev_in;
   logic [15:0]      prev_key_ff, prev_key_in;
   logic             pend_ff, pend_in;
   logic [15:0]      pend_key_ff, pend_key_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic             pend_new_ff, pend_new_in;
   logic             rsp_vld_ff, rsp_vld_in;

   logic        req_acc, mem_we, issue, scan_end, rsp_free, emit;
   logic [7:0]  in_b, in_u;
   logic [15:0] rd_data, rd_key;

   assign in_b     = req_tdata[7:0];
   assign in_u     = req_tdata[15:8];
   assign req_acc  = req_tvalid && req_tready;
   assign mem_we   = req_acc && (load_cnt_ff < CAP);
   assign issue    = (state_ff == sls_pkg::ST_SCAN) && (scan_cnt_ff < load_cnt_ff);
   assign scan_end = (state_ff == sls_pkg::ST_SCAN) && !issue && !rd_vld_ff;
   assign rsp_free = !rsp_vld_ff || rsp_tready;
   assign rd_key   = rd_data;

   sls_mem #(
      .DEPTH (SLOT_CAPACITY),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (load_cnt_ff[IDX_W-1:0]),
      .wr_data ({in_b, in_u}),
      .rd_addr (scan_cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   sls_pgdiv u_pgdiv (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .count     (occ_ff),
      .page_size (page_ff),
      .stat      (div_stat)
   );

   // page size register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff <= sls_pkg::PAGE_SIZE_RST;
      end else if (csr_valid) begin
         page_ff <= csr_data;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sls_pkg::ST_LOAD: if (req_acc && req_tlast) state_in = sls_pkg::ST_DIV;
         sls_pkg::ST_DIV:  if (div_stat.done) state_in = sls_pkg::ST_SCAN;
         sls_pkg::ST_SCAN: if (scan_end) state_in = sls_pkg::ST_EMIT;
         sls_pkg::ST_EMIT: begin
            if (found_ff) begin
               if (!pend_ff || rsp_free) state_in = sls_pkg::ST_SCAN;
            end else if (rsp_free) begin
               state_in = sls_pkg::ST_LOAD;
            end
         end
         default: state_in = sls_pkg::ST_LOAD;
      endcase
   end

   // handshake output
   always_comb begin
      req_tready = (state_ff == sls_pkg::ST_LOAD);
   end

   // load statistics, selection pass and emission
   always_comb begin
      load_cnt_in  = load_cnt_ff;
      occ_in       = occ_ff;
      bmin_in      = bmin_ff;
      bmax_in      = bmax_ff;
      umin_in      = umin_ff;
      umax_in      = umax_ff;
      pages_in     = pages_ff;
      scan_cnt_in  = scan_cnt_ff;
      rd_vld_in    = issue;
      found_in     = found_ff;
      best_key_in  = best_key_ff;
      best_idx_in  = best_idx_ff;
      have_prev_in = have_prev_ff;
      prev_key_in  = prev_key_ff;
      pend_in      = pend_ff;
      pend_key_in  = pend_key_ff;
      pend_idx_in  = pend_idx_ff;
      pend_new_in  = pend_new_ff;
      emit         = 1'b0;
      rsp_in       = rsp_ff;

      // slot load
      if (mem_we) begin
         load_cnt_in = load_cnt_ff + LC_W'(1);
         if (in_b != 8'd0) begin
            occ_in  = occ_ff + 7'd1;
            bmin_in = (in_b < bmin_ff) ? in_b : bmin_ff;
            bmax_in = (in_b > bmax_ff) ? in_b : bmax_ff;
            umin_in = (in_u < umin_ff) ? in_u : umin_ff;
            umax_in = (in_u > umax_ff) ? in_u : umax_ff;
         end
      end

      if (state_ff == sls_pkg::ST_DIV && div_stat.done) begin
         pages_in    = div_stat.pages;
         scan_cnt_in = '0;
         found_in    = 1'b0;
      end

      // scan: read address advances, compare on returned data
      if (issue) begin
         scan_cnt_in = scan_cnt_ff + LC_W'(1);
      end
      if (rd_vld_ff && rd_key[15:8] != 8'd0
          && !(have_prev_ff && rd_key <= prev_key_ff)
          && (!found_ff || rd_key < best_key_ff)) begin
         found_in    = 1'b1;
         best_key_in = rd_key;
         best_idx_in = rd_idx_ff;
      end

      // emission, one entry held back until the next pass shows if more follow
      rsp_in.sensor_count = occ_ff;
      rsp_in.page_count   = pages_ff;
      rsp_in.min_building = bmin_ff;
      rsp_in.max_building = bmax_ff;
      rsp_in.min_unit     = umin_ff;
      rsp_in.max_unit     = umax_ff;
      rsp_in.slot_index   = pend_ff ? 6'(pend_idx_ff) : 6'd0;
      rsp_in.out_building = pend_ff ? pend_key_ff[15:8] : 8'd0;
      rsp_in.out_unit     = pend_ff ? pend_key_ff[7:0] : 8'd0;
      rsp_in.new_building = pend_ff && pend_new_ff;
      rsp_in.valid_res    = pend_ff;
      rsp_in.last_result  = !found_ff;
      if (state_ff == sls_pkg::ST_EMIT) begin
         if (found_ff) begin
            if (!pend_ff || rsp_free) begin
               emit         = pend_ff;
               pend_in      = 1'b1;
               pend_key_in  = best_key_ff;
               pend_idx_in  = best_idx_ff;
               pend_new_in  = !have_prev_ff || (best_key_ff[15:8] != prev_key_ff[15:8]);
               have_prev_in = 1'b1;
               prev_key_in  = best_key_ff;
               scan_cnt_in  = '0;
               found_in     = 1'b0;
            end
         end else if (rsp_free) begin
            emit         = 1'b1;
            pend_in      = 1'b0;
            have_prev_in = 1'b0;
            load_cnt_in  = '0;
            occ_in       = 7'd0;
            bmin_in      = sls_pkg::NONE_MIN;
            bmax_in      = 8'd0;
            umin_in      = sls_pkg::NONE_MIN;
            umax_in      = 8'd0;
         end
      end
      if (!emit) begin
         rsp_in = rsp_ff;
      end
      rsp_vld_in = emit || (rsp_vld_ff && !rsp_tready);
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sls_pkg::ST_LOAD;
         load_cnt_ff  <= '0;
         occ_ff       <= 7'd0;
         bmin_ff      <= sls_pkg::NONE_MIN;
         bmax_ff      <= 8'd0;
         umin_ff      <= sls_pkg::NONE_MIN;
         umax_ff      <= 8'd0;
         div_start_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         have_prev_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         occ_ff       <= occ_in;
         bmin_ff      <= bmin_in;
         bmax_ff      <= bmax_in;
         umin_ff      <= umin_in;
         umax_ff      <= umax_in;
         div_start_ff <= req_acc && req_tlast;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         have_prev_ff <= have_prev_in;
         pend_ff      <= pend_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
      pages_ff    <= pages_in;
      scan_cnt_ff <= scan_cnt_in;
      rd_idx_ff   <= scan_cnt_ff[IDX_W-1:0];
      best_key_ff <= best_key_in;
      best_idx_ff <= best_idx_in;
      prev_key_ff <= prev_key_in;
      pend_key_ff <= pend_key_in;
      pend_idx_ff <= pend_idx_in;
      pend_new_ff <= pend_new_in;
      rsp_ff      <= rsp_in;
   end

   // output packing
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tlast  = rsp_ff.last_result;
   assign rsp_tuser  = {rsp_ff.valid_res, rsp_ff.new_building};
   assign rsp_tdata  = {4'd0, rsp_ff.max_unit, rsp_ff.min_unit, rsp_ff.max_building,
                        rsp_ff.min_building, rsp_ff.page_count, rsp_ff.sensor_count,
                        rsp_ff.out_unit, rsp_ff.out_building, rsp_ff.slot_index};

   // checks
   `SLS_ASSERT_IMP(a_we_in_load, clock, reset, mem_we, state_ff == sls_pkg::ST_LOAD, "store written outside load")
   `SLS_ASSERT_IMP(a_empty_is_last, clock, reset, rsp_vld_ff && !rsp_ff.valid_res, rsp_ff.last_result, "empty result not last")
   `SLS_ASSERT_IMP(a_pages_le_count, clock, reset, rsp_vld_ff, rsp_ff.page_count <= rsp_ff.sensor_count, "page count above sensor count")
   `SLS_ASSERT_NXT(a_read_in_range, clock, reset, issue, {1'b0, rd_idx_ff} < {1'b0, load_cnt_ff}, "read beyond loaded slots")

endmodule
